// ===== hw/rtl/mfbdr_pkg.sv =====
// Shared types, codes and constants of the monochrome frame buffer with
// dirty-rectangle flush. No dependencies; every other file in hw/rtl uses it.
`default_nettype none

package mfbdr_pkg;

	// Default geometry of the frame buffer
	localparam int ROWS_DEF = 64;
	localparam int COLS_DEF = 128;

	// Depth of the command queue between front and back
	localparam int QDEPTH = 2;

	// Input command codes
	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	// Pixel operation codes
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_SET    = 2'd1;
	localparam logic [1:0] MODE_INVERT = 2'd2;

	// Serial frame sync bytes and controller commands
	localparam logic [7:0] SYNC_CMD        = 8'hF8;
	localparam logic [7:0] SYNC_DATA       = 8'hFA;
	localparam logic [7:0] CMD_EXT_GRAPHIC = 8'h26;
	localparam logic [7:0] CMD_GDRAM_ADDR  = 8'h80;

	// Operations that travel through the queue
	typedef enum logic [1:0] {
		OP_PIX,
		OP_CLR,
		OP_FLUSH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] x;
		logic [7:0] y;
		logic [1:0] mode;
	} q_entry_t;

	// Build one three-byte serial frame: sync, high nibble, low nibble shifted up
	function automatic logic [23:0] make_frame(input logic [7:0] sync, input logic [7:0] v);
		make_frame = {sync, v[7:4], 4'h0, v[3:0], 4'h0};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mfbdr_front.sv =====
// Front end: accepts input items, drops ignored ones and classifies the rest
// into queue operations. Depends on mfbdr_pkg.
`default_nettype none

module mfbdr_front #(
	parameter int ROWS = mfbdr_pkg::ROWS_DEF,
	parameter int COLS = mfbdr_pkg::COLS_DEF
) (
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [15:0]          s_axis_tdata,  // x[7:0], y[15:8]
	input  wire logic [3:0]           s_axis_tuser,  // command[1:0], pixel_mode[3:2]
	input  wire logic                 q_full,
	output logic                      push,
	output mfbdr_pkg::q_entry_t       entry
);

	logic [1:0] command;
	logic [7:0] x;
	logic [7:0] y;
	logic       keep;

	assign command = s_axis_tuser[1:0];
	assign x       = s_axis_tdata[7:0];
	assign y       = s_axis_tdata[15:8];

	// Take an item whenever the queue has room
	assign s_axis_tready = !q_full;

	// Classify: out-of-range pixels and unused commands are dropped here
	always_comb begin
		entry.x    = x;
		entry.y    = y;
		entry.mode = s_axis_tuser[3:2];
		entry.op   = mfbdr_pkg::OP_PIX;
		keep       = 1'b0;
		case (command)
			mfbdr_pkg::CMD_PIXEL: begin
				entry.op = mfbdr_pkg::OP_PIX;
				keep     = (x < 8'(COLS)) && (y < 8'(ROWS));
			end
			mfbdr_pkg::CMD_CLEAR: begin
				entry.op = mfbdr_pkg::OP_CLR;
				keep     = 1'b1;
			end
			mfbdr_pkg::CMD_FLUSH: begin
				entry.op = mfbdr_pkg::OP_FLUSH;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = s_axis_tvalid && !q_full && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/mfbdr_queue.sv =====
// Short FIFO of classified operations between the front and the back end.
// Depends on mfbdr_pkg.
`default_nettype none

module mfbdr_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire mfbdr_pkg::q_entry_t  push_entry,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      head_valid,
	output mfbdr_pkg::q_entry_t       head
);

	localparam int PW = (mfbdr_pkg::QDEPTH > 1) ? $clog2(mfbdr_pkg::QDEPTH) : 1;
	localparam int CNTW = $clog2(mfbdr_pkg::QDEPTH + 1);

	mfbdr_pkg::q_entry_t entries_q [mfbdr_pkg::QDEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CNTW-1:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == CNTW'(mfbdr_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(mfbdr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(mfbdr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mfbdr_back.sv =====
// Back end: pixel store with row valid bits, dirty rectangle, flush sequencer
// and the output frame register. Depends on mfbdr_pkg.
`default_nettype none

module mfbdr_back #(
	parameter int ROWS = mfbdr_pkg::ROWS_DEF,
	parameter int COLS = mfbdr_pkg::COLS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire mfbdr_pkg::q_entry_t  head,
	output logic                      pop,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // frame[23:0]
	output logic                      m_axis_tuser,  // is_data
	output logic                      m_axis_tlast
);

	localparam int RW = $clog2(ROWS + 1);   // row count values
	localparam int RA = $clog2(ROWS);       // row index
	localparam int CW = $clog2(COLS + 1);   // column count values
	localparam int CA = $clog2(COLS);       // column index
	localparam int RB = COLS / 8;           // bytes per row
	localparam int BA = $clog2(RB);         // byte index within a row
	localparam int BW = $clog2(RB + 2);     // byte position, may run one past the row

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIX,
		ST_DATA
	} st_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MODE,
		PH_ADDR1,
		PH_ADDR2,
		PH_DATA
	} phase_t;

	// Pixel store, one row per word, MSB-left bytes at [8b+7:8b]
	logic [COLS-1:0] mem [ROWS];
	logic [COLS-1:0] rd_word_s1;
	logic            rd_vld_s1;
	logic [ROWS-1:0] row_vld_q;

	st_t             state_q;
	phase_t          phase_q;
	logic            ext_q;
	logic [RW-1:0]   row_first_q;
	logic [RW-1:0]   row_end_q;
	logic [CW-1:0]   col_first_q;
	logic [CW-1:0]   col_end_q;
	logic [RW-1:0]   fc_row_q;
	logic [RW-1:0]   fc_row_end_q;
	logic [BW-1:0]   fc_byte_q;
	logic [BW-1:0]   fc_byte_end_q;
	logic [BW-1:0]   fc_wfirst_q;
	logic [CA-1:0]   pix_x_q;
	logic [RA-1:0]   pix_y_q;
	logic [1:0]      pix_mode_q;
	logic [BA-1:0]   data_sel_q;
	logic            data_beyond_q;
	logic            out_valid_q;
	logic [23:0]     out_frame_q;
	logic            out_is_data_q;
	logic            out_last_q;

	logic            slot_free;
	logic            rect_empty;
	logic            starting;
	phase_t          ph_eff;
	logic [RW-1:0]   row_eff;
	logic            byte_carry;
	logic [RW-1:0]   data_row;
	logic            data_beyond;
	logic [BA-1:0]   data_sel;
	logic            rd_en;
	logic [RA-1:0]   rd_row;
	logic            wr_en;
	logic [COLS-1:0] old_word;
	logic [COLS-1:0] new_word;
	logic [CA-1:0]   bit_idx;
	logic [CW:0]     col_end_up;
	logic [BW-1:0]   nxt_byte;
	logic [RW-1:0]   nxt_row;
	logic [7:0]      data_byte;
	logic [7:0]      addr2_val;
	logic            frame_load;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_frame_q;
	assign m_axis_tuser  = out_is_data_q;
	assign m_axis_tlast  = out_last_q;

	// Flush decisions
	assign slot_free  = !out_valid_q || m_axis_tready;
	assign rect_empty = !((col_end_q > col_first_q) && (row_end_q > row_first_q));
	assign starting   = (phase_q == PH_IDLE) && !rect_empty;
	assign row_eff    = starting ? row_first_q : fc_row_q;
	assign col_end_up = (CW + 1)'(col_end_q) + (CW + 1)'(15);

	always_comb begin
		if (phase_q == PH_IDLE) begin
			if (starting) begin
				ph_eff = ext_q ? PH_ADDR1 : PH_MODE;
			end else begin
				ph_eff = PH_IDLE;
			end
		end else begin
			ph_eff = phase_q;
		end
	end

	// Data read position; the last byte of a word may fall onto the next row
	assign byte_carry  = (fc_byte_q == BW'(RB));
	assign data_row    = fc_row_q + RW'(byte_carry);
	assign data_beyond = (data_row >= RW'(ROWS));
	assign data_sel    = byte_carry ? '0 : fc_byte_q[BA-1:0];

	// Queue pop and memory read issue
	always_comb begin
		pop    = 1'b0;
		rd_en  = 1'b0;
		rd_row = data_row[RA-1:0];
		if (state_q == ST_IDLE && head_valid) begin
			case (head.op)
				mfbdr_pkg::OP_PIX: begin
					pop    = 1'b1;
					rd_en  = 1'b1;
					rd_row = head.y[RA-1:0];
				end
				mfbdr_pkg::OP_CLR: begin
					pop = 1'b1;
				end
				mfbdr_pkg::OP_FLUSH: begin
					pop   = slot_free;
					rd_en = slot_free && (ph_eff == PH_DATA);
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	// Load the output register on a command frame, or in ST_DATA for a data frame
	assign frame_load = (state_q == ST_DATA) ||
		((state_q == ST_IDLE) && head_valid && (head.op == mfbdr_pkg::OP_FLUSH) && slot_free &&
		(ph_eff inside {PH_MODE, PH_ADDR1, PH_ADDR2}));

	// Pixel read-modify-write on the fetched row
	assign old_word = rd_vld_s1 ? rd_word_s1 : '0;
	assign bit_idx  = {pix_x_q[CA-1:3], ~pix_x_q[2:0]};
	assign wr_en    = (state_q == ST_PIX);

	always_comb begin
		new_word = old_word;
		case (pix_mode_q)
			mfbdr_pkg::MODE_CLEAR:  new_word[bit_idx] = 1'b0;
			mfbdr_pkg::MODE_SET:    new_word[bit_idx] = 1'b1;
			mfbdr_pkg::MODE_INVERT: new_word[bit_idx] = ~old_word[bit_idx];
			default:                new_word = old_word;
		endcase
	end

	// Frame values
	assign data_byte = (!rd_vld_s1 || data_beyond_q) ? 8'h00 :
		rd_word_s1[{data_sel_q, 3'b000} +: 8];
	assign addr2_val = mfbdr_pkg::CMD_GDRAM_ADDR | 8'(fc_wfirst_q) | {4'h0, row_eff[5], 3'b000};
	assign nxt_byte  = fc_byte_q + BW'(1);
	assign nxt_row   = fc_row_q + RW'(1);

	// Row memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pix_y_q] <= new_word;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_row];
		end
	end

	// Sequencer, rectangle, flush cursor and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_IDLE;
			ext_q         <= 1'b0;
			row_vld_q     <= '0;
			rd_vld_s1     <= 1'b0;
			row_first_q   <= RW'(ROWS);
			row_end_q     <= '0;
			col_first_q   <= CW'(COLS);
			col_end_q     <= '0;
			fc_row_q      <= '0;
			fc_row_end_q  <= '0;
			fc_byte_q     <= '0;
			fc_byte_end_q <= '0;
			fc_wfirst_q   <= '0;
			pix_x_q       <= '0;
			pix_y_q       <= '0;
			pix_mode_q    <= '0;
			data_sel_q    <= '0;
			data_beyond_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_frame_q   <= '0;
			out_is_data_q <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			// Hold a frame until taken, then load the next one
			if (frame_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_vld_s1 <= row_vld_q[rd_row];
			end
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						case (head.op)
							mfbdr_pkg::OP_PIX: begin
								pix_x_q    <= head.x[CA-1:0];
								pix_y_q    <= head.y[RA-1:0];
								pix_mode_q <= head.mode;
								state_q    <= ST_PIX;
							end
							mfbdr_pkg::OP_CLR: begin
								row_vld_q   <= '0;
								row_first_q <= '0;
								row_end_q   <= RW'(ROWS);
								col_first_q <= '0;
								col_end_q   <= CW'(COLS);
							end
							mfbdr_pkg::OP_FLUSH: begin
								if (slot_free) begin
									// Latch and empty the rectangle on the first step
									if (starting) begin
										fc_row_q      <= row_first_q;
										fc_row_end_q  <= row_end_q;
										fc_wfirst_q   <= BW'(col_first_q >> 4);
										fc_byte_end_q <= BW'((col_end_up >> 4) << 1);
										row_first_q   <= RW'(ROWS);
										row_end_q     <= '0;
										col_first_q   <= CW'(COLS);
										col_end_q     <= '0;
									end
									case (ph_eff)
										PH_MODE: begin
											out_frame_q   <= mfbdr_pkg::make_frame(
												mfbdr_pkg::SYNC_CMD, mfbdr_pkg::CMD_EXT_GRAPHIC);
											out_is_data_q <= 1'b0;
											out_last_q    <= 1'b0;
											ext_q         <= 1'b1;
											phase_q       <= PH_ADDR1;
										end
										PH_ADDR1: begin
											out_frame_q   <= mfbdr_pkg::make_frame(
												mfbdr_pkg::SYNC_CMD,
												mfbdr_pkg::CMD_GDRAM_ADDR | {3'b000, row_eff[4:0]});
											out_is_data_q <= 1'b0;
											out_last_q    <= 1'b0;
											phase_q       <= PH_ADDR2;
										end
										PH_ADDR2: begin
											out_frame_q   <= mfbdr_pkg::make_frame(
												mfbdr_pkg::SYNC_CMD, addr2_val);
											out_is_data_q <= 1'b0;
											out_last_q    <= 1'b0;
											fc_byte_q     <= fc_wfirst_q << 1;
											phase_q       <= PH_DATA;
										end
										PH_DATA: begin
											data_sel_q    <= data_sel;
											data_beyond_q <= data_beyond;
											state_q       <= ST_DATA;
										end
										default: begin
											phase_q <= phase_q;
										end
									endcase
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PIX: begin
					// Row is now written in full; grow the rectangle
					row_vld_q[pix_y_q] <= 1'b1;
					if (row_first_q > RW'(pix_y_q)) begin
						row_first_q <= RW'(pix_y_q);
					end
					if (row_end_q <= RW'(pix_y_q)) begin
						row_end_q <= RW'(pix_y_q) + RW'(1);
					end
					if (col_first_q > CW'(pix_x_q)) begin
						col_first_q <= CW'(pix_x_q);
					end
					if (col_end_q <= CW'(pix_x_q)) begin
						col_end_q <= CW'(pix_x_q) + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_DATA: begin
					out_frame_q   <= mfbdr_pkg::make_frame(mfbdr_pkg::SYNC_DATA, data_byte);
					out_is_data_q <= 1'b1;
					out_last_q    <= (nxt_byte >= fc_byte_end_q) && (nxt_row >= fc_row_end_q);
					fc_byte_q     <= nxt_byte;
					// Advance to the next row or finish the flush
					if (nxt_byte >= fc_byte_end_q) begin
						fc_row_q <= nxt_row;
						if (nxt_row >= fc_row_end_q) begin
							phase_q <= PH_IDLE;
						end else begin
							phase_q <= PH_ADDR1;
						end
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mono_framebuffer_dirty_rect_flush_top.sv =====
// Monochrome frame buffer with dirty-rectangle flush to a serial graphic LCD.
// Input items carry pixel, clear and flush-step commands; each flush step
// yields one three-byte serial frame unless no flush is open and the dirty
// rectangle is empty. A pixel write reads the row, then writes it back in the
// back end. A clear needs no clearing pass, since every row has a valid bit
// that reset and clear drop at once. A command frame goes straight into the
// output register; a data frame reads the row, then selects the byte. Unused
// commands and off-screen pixels are dropped at the input without reaching
// the back end. A two-entry queue between input and back end keeps the input
// taking items while a frame waits at the output.
// Depends on mfbdr_pkg, mfbdr_front, mfbdr_queue and mfbdr_back.
`default_nettype none

module mono_framebuffer_dirty_rect_flush_top #(
	parameter int ROWS = mfbdr_pkg::ROWS_DEF,
	parameter int COLS = mfbdr_pkg::COLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // x[7:0], y[15:8]
	input  wire logic [3:0]  s_axis_tuser,  // command[1:0], pixel_mode[3:2]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // frame[23:0]
	output logic             m_axis_tuser,  // is_data
	output logic             m_axis_tlast   // last
);

	mfbdr_pkg::q_entry_t push_entry;
	mfbdr_pkg::q_entry_t head;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                head_valid;

	mfbdr_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_full       (q_full),
		.push         (push),
		.entry        (push_entry)
	);

	mfbdr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	mfbdr_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the monochrome frame buffer with dirty-rectangle flush.
// Streams pixel, clear and flush-step items into the top level and checks every
// serial frame against a built-in frame buffer model. Depends on mfbdr_pkg.
`timescale 1ns / 1ps

module tb;

	localparam int ROWS         = mfbdr_pkg::ROWS_DEF;
	localparam int COLS         = mfbdr_pkg::COLS_DEF;
	localparam int ROW_BYTES    = COLS / 8;
	localparam int TOTAL_ITEMS  = 900;
	localparam int TAIL_ITEMS   = 80;
	localparam int CLEAR_STEPS  = 40;
	localparam int PAUSE_EVERY  = 150;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 32;

	// Codes the block must ignore
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [23:0] frame;
		logic        is_data;
		logic        last;
	} lcd_frame_t;

	typedef enum logic [2:0] {
		FL_IDLE,
		FL_MODE,
		FL_ROW_ADDR,
		FL_COL_ADDR,
		FL_DATA
	} flush_phase_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_BLOCKED,
		RX_CHOPPY
	} rx_pattern_t;

	// Frame buffer model plus the queue of frames still owed by the block
	class flush_scoreboard;
		bit [7:0]     image [ROWS*ROW_BYTES];
		int unsigned  row_lo, row_hi, col_lo, col_hi;
		bit           graphic_mode;
		flush_phase_t phase;
		int unsigned  cur_row, cur_byte, end_row, word_lo, word_hi;
		lcd_frame_t   frames_due[$];
		int           errors;

		function new();
			foreach (image[i]) image[i] = 8'h00;
			empty_rect();
			graphic_mode = 1'b0;
			phase = FL_IDLE;
			errors = 0;
		endfunction

		function void empty_rect();
			row_lo = ROWS;
			row_hi = 0;
			col_lo = COLS;
			col_hi = 0;
		endfunction

		function bit flushing();
			return phase != FL_IDLE;
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		task report(input string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		// Apply one accepted item and queue the frame it owes, if any
		function void note_item(input logic [1:0] cmd, input logic [7:0] x, input logic [7:0] y,
				input logic [1:0] mode);
			int unsigned idx;
			logic [7:0]  mask, val, sync;
			lcd_frame_t  fr;
			case (cmd)
			mfbdr_pkg::CMD_PIXEL: begin
				if (x < COLS && y < ROWS) begin
					idx = y * ROW_BYTES + x / 8;
					mask = 8'h80 >> x[2:0];
					case (mode)
					mfbdr_pkg::MODE_CLEAR:  image[idx] = image[idx] & ~mask;
					mfbdr_pkg::MODE_SET:    image[idx] = image[idx] | mask;
					mfbdr_pkg::MODE_INVERT: image[idx] = image[idx] ^ mask;
					default: ;
					endcase
					if (row_lo > y) row_lo = y;
					if (row_hi <= y) row_hi = y + 1;
					if (col_lo > x) col_lo = x;
					if (col_hi <= x) col_hi = x + 1;
				end
			end
			mfbdr_pkg::CMD_CLEAR: begin
				foreach (image[i]) image[i] = 8'h00;
				row_lo = 0;
				row_hi = ROWS;
				col_lo = 0;
				col_hi = COLS;
			end
			mfbdr_pkg::CMD_FLUSH: begin
				// Latch and empty the rectangle on the first step of a flush
				if (phase == FL_IDLE && col_hi > col_lo && row_hi > row_lo) begin
					cur_row = row_lo;
					end_row = row_hi;
					word_lo = col_lo / 16;
					word_hi = (col_hi + 15) / 16;
					empty_rect();
					phase = graphic_mode ? FL_ROW_ADDR : FL_MODE;
				end
				if (phase != FL_IDLE) begin
					fr.last = 1'b0;
					sync = mfbdr_pkg::SYNC_CMD;
					case (phase)
					FL_MODE: begin
						val = mfbdr_pkg::CMD_EXT_GRAPHIC;
						graphic_mode = 1'b1;
						phase = FL_ROW_ADDR;
					end
					FL_ROW_ADDR: begin
						val = mfbdr_pkg::CMD_GDRAM_ADDR | 8'(cur_row & 31);
						phase = FL_COL_ADDR;
					end
					FL_COL_ADDR: begin
						val = mfbdr_pkg::CMD_GDRAM_ADDR | 8'(word_lo) | 8'((cur_row & 32) >> 2);
						cur_byte = 2 * word_lo;
						phase = FL_DATA;
					end
					default: begin
						sync = mfbdr_pkg::SYNC_DATA;
						idx = cur_row * ROW_BYTES + cur_byte;
						val = (idx < ROWS * ROW_BYTES) ? image[idx] : 8'h00;
						cur_byte++;
						if (cur_byte >= 2 * word_hi) begin
							cur_row++;
							if (cur_row >= end_row) begin
								phase = FL_IDLE;
								fr.last = 1'b1;
							end else begin
								phase = FL_ROW_ADDR;
							end
						end
					end
					endcase
					fr.frame = {sync, val & 8'hF0, 8'(val << 4)};
					fr.is_data = (sync == mfbdr_pkg::SYNC_DATA);
					frames_due.push_back(fr);
				end
			end
			default: ;
			endcase
		endfunction

		// Compare one accepted frame with the oldest one owed
		task check_result(input logic [23:0] frame, input logic is_data, input logic last);
			lcd_frame_t want;
			if (frames_due.size() == 0) begin
				report($sformatf("unexpected frame %06h", frame));
			end else begin
				want = frames_due.pop_front();
				if (frame !== want.frame)
					report($sformatf("frame %06h, want %06h", frame, want.frame));
				if (is_data !== want.is_data)
					report($sformatf("is_data %b, want %b", is_data, want.is_data));
				if (last !== want.last)
					report($sformatf("last %b, want %b", last, want.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [15:0] s_axis_tdata  = '0;
	logic [3:0]  s_axis_tuser  = '0;
	logic        m_axis_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	flush_scoreboard sb;
	int unsigned     cycle_count = 0;
	int              burst_left = 0;
	int unsigned     counted = 0;

	mono_framebuffer_dirty_rect_flush_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: open runs, blocked runs and choppy runs
	rx_pattern_t rx_kind = RX_OPEN;
	int          rx_left = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_kind = rx_pattern_t'($urandom_range(0, 2));
			rx_left = (rx_kind == RX_BLOCKED) ? $urandom_range(1, 12) : $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_kind)
		RX_OPEN:    m_axis_tready <= 1'b1;
		RX_BLOCKED: m_axis_tready <= 1'b0;
		default:    m_axis_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Check every accepted frame
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// Send one item, opening a new burst after a random gap when the last one ran out
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] x, input logic [7:0] y,
			input logic [1:0] mode);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 7))
			0, 1:    gap = 0;
			7:       gap = $urandom_range(5, 20);
			default: gap = $urandom_range(1, 4);
			endcase
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tuser <= {mode, cmd};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, x, y, mode);
		counted++;
		burst_left--;
	endtask

	task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic [1:0] mode);
		send_item(mfbdr_pkg::CMD_PIXEL, x, y, mode);
	endtask

	// Flush step with don't-care fields randomized
	task automatic send_flush();
		send_item(mfbdr_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			2'($urandom_range(0, 3)));
	endtask

	// Noise: off-screen pixels, unused codes, full-range fields
	task automatic send_stray();
		logic [7:0] x, y;
		x = 8'($urandom_range(0, 255));
		y = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
		0: send_pixel(x, y, 2'($urandom_range(0, 3)));
		1: send_pixel(8'($urandom_range(COLS, 255)), y, mfbdr_pkg::MODE_SET);
		2: send_item(CMD_UNUSED, x, y, 2'($urandom_range(0, 3)));
		default: send_pixel(8'($urandom_range(0, COLS - 1)), 8'($urandom_range(0, ROWS - 1)),
			MODE_UNUSED);
		endcase
	endtask

	// Step a flush to its end, mixing in stray items
	task automatic run_flush(input int stray_pct);
		do begin
			if ($urandom_range(0, 99) < stray_pct) send_stray();
			send_flush();
		end while (sb.flushing());
	endtask

	// Hold off the sender until every owed frame has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic random_sequence();
		int x0, y0, w, h, n;
		x0 = $urandom_range(0, COLS - 1);
		y0 = $urandom_range(0, ROWS - 1);
		w = $urandom_range(1, 24);
		h = $urandom_range(1, 4);
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				send_stray();
			else
				send_pixel(8'(x0 + $urandom_range(0, w - 1)), 8'(y0 + $urandom_range(0, h - 1)),
					2'($urandom_range(0, 3)));
		end
		// Now and then leave a flush half done
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 4)) send_flush();
		else
			run_flush(10);
	endtask

	initial begin
		int next_pause;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Empty rectangle and unused command give nothing
		send_flush();
		send_item(CMD_UNUSED, 8'hFF, 8'hFF, mfbdr_pkg::MODE_SET);
		// Corners, unused mode, off-screen coordinates; first flush switches mode
		send_pixel(8'd0, 8'd0, mfbdr_pkg::MODE_SET);
		send_pixel(8'd17, 8'd1, MODE_UNUSED);
		send_pixel(8'd128, 8'd0, mfbdr_pkg::MODE_SET);
		send_pixel(8'd0, 8'd64, mfbdr_pkg::MODE_SET);
		send_pixel(8'd255, 8'd255, mfbdr_pkg::MODE_INVERT);
		run_flush(0);
		// Far corner, all modes, then writes during a flush
		send_pixel(8'd127, 8'd63, mfbdr_pkg::MODE_SET);
		send_pixel(8'd126, 8'd63, mfbdr_pkg::MODE_INVERT);
		send_pixel(8'd125, 8'd63, mfbdr_pkg::MODE_SET);
		send_pixel(8'd125, 8'd63, mfbdr_pkg::MODE_CLEAR);
		send_flush();
		send_flush();
		send_pixel(8'd126, 8'd63, mfbdr_pkg::MODE_INVERT);
		send_pixel(8'd120, 8'd62, mfbdr_pkg::MODE_SET);
		run_flush(0);
		run_flush(0);
		wait_drained();

		next_pause = PAUSE_EVERY;
		while (counted < TOTAL_ITEMS - TAIL_ITEMS) begin
			random_sequence();
			if (counted >= next_pause) begin
				wait_drained();
				next_pause += PAUSE_EVERY;
			end
		end

		// Finish any open flush, then clear in the middle of a flush
		run_flush(0);
		send_pixel(8'd5, 8'd10, mfbdr_pkg::MODE_SET);
		send_pixel(8'd20, 8'd10, mfbdr_pkg::MODE_SET);
		repeat (3) send_flush();
		send_item(mfbdr_pkg::CMD_CLEAR, 8'd0, 8'd0, mfbdr_pkg::MODE_CLEAR);
		run_flush(0);
		// Open the full-screen flush and write inside its span
		repeat (3) send_flush();
		send_pixel(8'd12, 8'd0, mfbdr_pkg::MODE_SET);
		repeat (CLEAR_STEPS) send_flush();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mfbdr_pkg.sv
hw/rtl/mfbdr_front.sv
hw/rtl/mfbdr_queue.sv
hw/rtl/mfbdr_back.sv
hw/rtl/mono_framebuffer_dirty_rect_flush_top.sv
bench/tb.sv
